// File: hdl/pwgfs_pkg.sv
// Shared types, constants and helpers for the pulse-width gain frame sender.
// No dependencies.
package pwgfs_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int TICK_WIDTH  = 16;
   localparam int FRAME_BITS  = 38;
   localparam int BITS_WIDTH  = $clog2(FRAME_BITS + 1);
   localparam int CSR_IDX_W   = 2;

   localparam logic [31:0] COUNT_MAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

   localparam logic [7:0] GAIN2_MAX = 8'h07;
   localparam logic [7:0] GAIN1_MAX = 8'h7f;

   typedef enum logic [2:0] {
      STATUS_NONE      = 3'd0,
      STATUS_STARTED   = 3'd1,
      STATUS_RANGE     = 3'd2,
      STATUS_UNSUPP    = 3'd3,
      STATUS_BUSY      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FUNC_NONE     = 2'd0,
      FUNC_SIMULATE = 2'd1,
      FUNC_PROGRAM  = 2'd2,
      FUNC_READ     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      PARAM_GAIN2 = 2'd0,
      PARAM_GAIN1 = 2'd1,
      PARAM_RSV2  = 2'd2,
      PARAM_RSV3  = 2'd3
   } param_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG  = 2'd0,
      CSR_SHORT = 2'd1,
      CSR_GAP   = 2'd2,
      CSR_NONE  = 2'd3
   } csr_idx_type;

   localparam logic [TICK_WIDTH-1:0] LONG_RESET  = 16'd1000;
   localparam logic [TICK_WIDTH-1:0] SHORT_RESET = 16'd10;
   localparam logic [TICK_WIDTH-1:0] GAP_RESET   = 16'd100;

   // zero acts as one, values beyond the counter saturate
   function automatic logic [COUNT_WIDTH-1:0] phase_len(input logic [TICK_WIDTH-1:0] len);
      logic [31:0] wide;
      wide = {{(32 - TICK_WIDTH){1'b0}}, len};
      if (wide == 32'd0) begin
         wide = 32'd1;
      end
      if (wide > COUNT_MAX32) begin
         wide = COUNT_MAX32;
      end
      return wide[COUNT_WIDTH-1:0];
   endfunction

   // start 100000000001, function, parameter, 10, value, end 011111111110
   function automatic logic [FRAME_BITS-1:0] build_frame(input logic [1:0] func,
                                                         input logic [1:0] param,
                                                         input logic [7:0] val);
      return {8'h80, 4'b0001, func, param, 2'b10, val, 6'b011111, 6'b111110};
   endfunction

endpackage

// File: hdl/pulse_width_gain_frame_sender.sv
// Pulse-width gain frame sender: request check, frame build and pin sequencing.
// Depends on pwgfs_pkg.
//
// Usage:
//   req_* channel carries one item per transfer: req_cmd = 0 is a time tick,
//   req_cmd = 1 asks to send a frame built from function, parameter and value.
//   Every item gives exactly one rsp_* transfer: pin level, busy flag, status
//   of the request and a done flag on the tick that closes the last gap.
//   csr_* writes the long pulse, short pulse and gap lengths in ticks; it is
//   always ready. A new length applies from the next phase that starts.
//   The result is registered and is valid in the cycle after the input transfer.
//   Throughput: one item per cycle; a single output register sits between
//   the two sides, and an item is taken whenever that register is empty or
//   is being drained in the same cycle.
//   When rsp_stall holds, the result stays put and req_stall rises only while
//   the output register is full.
//   Reset (synchronous, active high) returns to idle, marks the output register
//   empty without resetting its data, and restores the default lengths 1000, 10 and 100.
module pulse_width_gain_frame_sender
   import pwgfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [1:0]            req_function_code,
   input  logic [1:0]            req_parameter_code,
   input  logic [7:0]            req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_pin_level,
   output logic                  rsp_busy_res,
   output logic [2:0]            rsp_status,
   output logic                  rsp_frame_done,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TICK_WIDTH-1:0] csr_data
);

   logic [TICK_WIDTH-1:0]  long_ff, short_ff, gap_ff;
   logic [FRAME_BITS-1:0]  frame_ff, frame_in;
   logic [BITS_WIDTH-1:0]  bits_ff, bits_in;
   logic                   gap_phase_ff, gap_phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in, count_dec;
   logic                   sending_ff, sending_in;
   logic                   valid_ff;
   logic                   pin_ff, busy_ff, done_ff, done_in;
   status_type             status_ff, status_in;
   logic                   req_xfer;
   logic [FRAME_BITS-1:0]  new_frame, shifted;

   assign req_stall = valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff  <= LONG_RESET;
         short_ff <= SHORT_RESET;
         gap_ff   <= GAP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LONG:  long_ff  <= csr_data;
            CSR_SHORT: short_ff <= csr_data;
            CSR_GAP:   gap_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      status_in = STATUS_NONE;
      if (sending_ff) begin
         status_in = STATUS_BUSY;
      end else begin
         unique case (func_type'(req_function_code))
            FUNC_NONE: status_in = STATUS_UNSUPP;
            FUNC_READ: status_in = STATUS_STARTED;
            default: begin
               case (param_type'(req_parameter_code))
                  PARAM_GAIN2: status_in = (req_value > GAIN2_MAX) ? STATUS_RANGE
                                                                  : STATUS_STARTED;
                  PARAM_GAIN1: status_in = (req_value > GAIN1_MAX) ? STATUS_RANGE
                                                                  : STATUS_STARTED;
                  default:     status_in = STATUS_UNSUPP;
               endcase
            end
         endcase
      end
   end

   assign new_frame = build_frame(req_function_code, req_parameter_code, req_value);
   assign shifted   = {frame_ff[FRAME_BITS-2:0], 1'b0};
   assign count_dec = count_ff - 1'b1;

   always_comb begin
      frame_in     = frame_ff;
      bits_in      = bits_ff;
      gap_phase_in = gap_phase_ff;
      count_in     = count_ff;
      sending_in   = sending_ff;
      done_in      = 1'b0;
      if (req_cmd) begin
         if (status_in == STATUS_STARTED) begin
            frame_in     = new_frame;
            bits_in      = BITS_WIDTH'(FRAME_BITS);
            sending_in   = 1'b1;
            gap_phase_in = 1'b0;
            count_in     = phase_len(new_frame[FRAME_BITS-1] ? long_ff : short_ff);
         end
      end else if (sending_ff) begin
         count_in = count_dec;
         if (count_dec == '0) begin
            if (!gap_phase_ff) begin
               gap_phase_in = 1'b1;
               count_in     = phase_len(gap_ff);
            end else begin
               bits_in  = bits_ff - 1'b1;
               frame_in = shifted;
               if (bits_in == '0) begin
                  sending_in   = 1'b0;
                  gap_phase_in = 1'b0;
                  done_in      = 1'b1;
               end else begin
                  gap_phase_in = 1'b0;
                  count_in     = phase_len(shifted[FRAME_BITS-1] ? long_ff : short_ff);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= '0;
         bits_ff      <= '0;
         gap_phase_ff <= 1'b0;
         count_ff     <= '0;
         sending_ff   <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         if (req_xfer) begin
            frame_ff     <= frame_in;
            bits_ff      <= bits_in;
            gap_phase_ff <= gap_phase_in;
            count_ff     <= count_in;
            sending_ff   <= sending_in;
            valid_ff     <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pin_ff    <= sending_in & ~gap_phase_in;
         busy_ff   <= sending_in;
         status_ff <= req_cmd ? status_in : STATUS_NONE;
         done_ff   <= done_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pin_level  = pin_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_status     = status_ff;
   assign rsp_frame_done = done_ff;

`ifndef SYNTHESIS
   a_idle_no_gap: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> !gap_phase_ff)
      else $error("gap phase while idle");

   a_bits_nonzero: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> bits_ff != '0)
      else $error("sending with no bits left");

   a_pin_implies_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pin_level |-> rsp_busy_res)
      else $error("pin high while not busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_busy_res && !rsp_pin_level)
      else $error("frame done while still busy");

   a_start_sends: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_cmd && status_in == STATUS_STARTED |=> sending_ff && !gap_phase_ff)
      else $error("accepted request did not start a frame");
`endif

endmodule

// File: tb/sv/pulse_width_gain_frame_sender_tb.sv
// Self-checking testbench for pulse_width_gain_frame_sender: a bit-level predictor
// of request checks and pin sequencing, checked against every result transfer.
// Depends on pwgfs_pkg and the RTL of the block.
module pulse_width_gain_frame_sender_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pwgfs_pkg::*;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SEND = 1'b1;
   localparam logic [11:0] START_FIELD = 12'b1000_0000_0001;
   localparam logic [11:0] END_FIELD   = 12'b0111_1111_1110;
   localparam int unsigned LIMIT_CYCLES = 2_000_000;

   typedef struct packed {
      logic       pin;
      logic       busy;
      status_type status;
      logic       done;
   } pin_result_type;

   class frame_scoreboard;
      logic [TICK_WIDTH-1:0]  long_len  = LONG_RESET;
      logic [TICK_WIDTH-1:0]  short_len = SHORT_RESET;
      logic [TICK_WIDTH-1:0]  gap_len   = GAP_RESET;
      logic [FRAME_BITS-1:0]  frame_bits = '0;
      logic [BITS_WIDTH-1:0]  bits_left = '0;
      logic [COUNT_WIDTH-1:0] phase_count = '0;
      logic                   in_gap = 1'b0;
      logic                   sending = 1'b0;
      pin_result_type         expected_q[$];
      int                     errors = 0;

      function void write_reg(csr_idx_type idx, logic [TICK_WIDTH-1:0] data);
         case (idx)
            CSR_LONG:  long_len = data;
            CSR_SHORT: short_len = data;
            CSR_GAP:   gap_len = data;
            default: ;
         endcase
      endfunction

      function logic [COUNT_WIDTH-1:0] ticks_of(logic [TICK_WIDTH-1:0] len);
         longint n;
         n = (len == '0) ? 1 : longint'(len);
         if (n > (longint'(1) << COUNT_WIDTH) - 1) n = (longint'(1) << COUNT_WIDTH) - 1;
         return n[COUNT_WIDTH-1:0];
      endfunction

      function void load_bit();
         in_gap = 1'b0;
         phase_count = ticks_of(frame_bits[FRAME_BITS-1] ? long_len : short_len);
      endfunction

      function status_type judge(logic [1:0] f, logic [1:0] p, logic [7:0] v);
         if (f == FUNC_NONE) return STATUS_UNSUPP;
         if (f == FUNC_READ) return STATUS_STARTED;
         if (p == PARAM_GAIN2) return (v > GAIN2_MAX) ? STATUS_RANGE : STATUS_STARTED;
         if (p == PARAM_GAIN1) return (v > GAIN1_MAX) ? STATUS_RANGE : STATUS_STARTED;
         return STATUS_UNSUPP;
      endfunction

      function void note_item(logic cmd, logic [1:0] f, logic [1:0] p, logic [7:0] v);
         pin_result_type r;
         status_type     st;
         st = STATUS_NONE;
         r.done = 1'b0;
         if (cmd == CMD_SEND) begin
            st = sending ? STATUS_BUSY : judge(f, p, v);
            if (st == STATUS_STARTED) begin
               frame_bits = {START_FIELD, f, p, 2'b10, v, END_FIELD};
               bits_left = BITS_WIDTH'(FRAME_BITS);
               sending = 1'b1;
               load_bit();
            end
         end else if (sending) begin
            phase_count = phase_count - 1'b1;
            if (phase_count == '0) begin
               if (!in_gap) begin
                  in_gap = 1'b1;
                  phase_count = ticks_of(gap_len);
               end else begin
                  bits_left = bits_left - 1'b1;
                  frame_bits = frame_bits << 1;
                  if (bits_left == '0) begin
                     sending = 1'b0;
                     in_gap = 1'b0;
                     r.done = 1'b1;
                  end else begin
                     load_bit();
                  end
               end
            end
         end
         r.pin = sending && !in_gap;
         r.busy = sending;
         r.status = st;
         expected_q.push_back(r);
      endfunction

      function void compare(string field, logic [2:0] want, logic [2:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         end
      endfunction

      function void check_result(logic pin, logic busy, logic [2:0] status, logic done);
         pin_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result transfer with none expected, status %0d", $time, status);
            return;
         end
         want = expected_q.pop_front();
         compare("pin_level", 3'(want.pin), 3'(pin));
         compare("busy_res", 3'(want.busy), 3'(busy));
         compare("status", want.status, status);
         compare("frame_done", 3'(want.done), 3'(done));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_cmd;
   logic [1:0]            req_function_code;
   logic [1:0]            req_parameter_code;
   logic [7:0]            req_value;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_pin_level;
   logic                  rsp_busy_res;
   logic [2:0]            rsp_status;
   logic                  rsp_frame_done;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [TICK_WIDTH-1:0] csr_data;

   int unsigned     cycle_count = 0;
   int unsigned     req_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;
   frame_scoreboard sb;

   pulse_width_gain_frame_sender dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_function_code(req_function_code),
      .req_parameter_code(req_parameter_code),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pin_level(rsp_pin_level),
      .rsp_busy_res(rsp_busy_res),
      .rsp_status(rsp_status),
      .rsp_frame_done(rsp_frame_done),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(rsp_pin_level, rsp_busy_res, rsp_status, rsp_frame_done);
   end

   // valid stays high on return; the next call or drain decides what follows
   task automatic send_item(input logic cmd, input logic [1:0] f, input logic [1:0] p,
                            input logic [7:0] v);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_function_code <= f;
      req_parameter_code <= p;
      req_value <= v;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_item(cmd, f, p, v);
   endtask

   task automatic tick();
      send_item(CMD_TICK, 2'($urandom_range(3)), 2'($urandom_range(3)),
                8'($urandom_range(255)));
   endtask

   task automatic finish_frame();
      while (sb.sending) tick();
   endtask

   task automatic send_request_good();
      logic [1:0] f;
      logic [1:0] p;
      logic [7:0] v;
      f = 2'($urandom_range(1, 3));
      if (f == FUNC_READ) begin
         p = 2'($urandom_range(3));
         v = 8'($urandom_range(255));
      end else begin
         p = 2'($urandom_range(1));
         v = (p == PARAM_GAIN2) ? 8'($urandom_range(GAIN2_MAX)) : 8'($urandom_range(GAIN1_MAX));
      end
      send_item(CMD_SEND, f, p, v);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [TICK_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, data);
   endtask

   task automatic set_lengths(input logic [TICK_WIDTH-1:0] long_t,
                              input logic [TICK_WIDTH-1:0] short_t,
                              input logic [TICK_WIDTH-1:0] gap_t);
      drain();
      write_csr(CSR_LONG, long_t);
      write_csr(CSR_SHORT, short_t);
      write_csr(CSR_GAP, gap_t);
      if ($urandom_range(1)) write_csr(CSR_NONE, TICK_WIDTH'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [TICK_WIDTH-1:0] pick_len();
      return TICK_WIDTH'($urandom_range(0, 3));
   endfunction

   task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct,
                            input int count);
      int  taken;
      int  roll;
      logic paused;
      req_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
      set_lengths(pick_len(), pick_len(), pick_len());
      taken = 0;
      paused = 1'b0;
      while (taken < count) begin
         roll = $urandom_range(99);
         if ((!paused && taken >= count / 2) || (sb.sending && $urandom_range(199) == 0)) begin
            paused = 1'b1;
            set_lengths(pick_len(), pick_len(), pick_len());
         end
         if (sb.sending) begin
            if (roll < 4) send_item(CMD_SEND, 2'($urandom_range(3)), 2'($urandom_range(3)),
                                    8'($urandom_range(255)));
            else tick();
            taken++;
         end else if (roll < 75) begin
            send_request_good();
            taken++;
         end else if (roll < 90) begin
            send_item(CMD_SEND, 2'($urandom_range(3)), 2'($urandom_range(3)),
                      8'($urandom_range(255)));
            taken++;
         end else begin
            tick();
         end
      end
   endtask

   initial begin
      sb = new;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_TICK;
      req_function_code <= FUNC_NONE;
      req_parameter_code <= PARAM_GAIN2;
      req_value <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_LONG;
      csr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 25;
      rsp_stall_pct = 78;
      tick();
      send_item(CMD_SEND, FUNC_NONE, PARAM_GAIN1, 8'h00);
      send_item(CMD_SEND, FUNC_SIMULATE, PARAM_GAIN2, 8'h08);
      send_item(CMD_SEND, FUNC_PROGRAM, PARAM_GAIN2, 8'hff);
      send_item(CMD_SEND, FUNC_SIMULATE, PARAM_GAIN1, 8'h80);
      send_item(CMD_SEND, FUNC_PROGRAM, PARAM_GAIN1, 8'hff);
      send_item(CMD_SEND, FUNC_SIMULATE, PARAM_RSV2, 8'h00);
      send_item(CMD_SEND, FUNC_PROGRAM, PARAM_RSV3, 8'h01);
      tick();
      // default lengths, then shortened while the first pulse is still high
      send_item(CMD_SEND, FUNC_READ, PARAM_GAIN2, 8'h00);
      send_item(CMD_SEND, FUNC_SIMULATE, PARAM_GAIN2, 8'h00);
      repeat (20) tick();
      set_lengths(16'd2, 16'd0, 16'd1);
      finish_frame();
      send_item(CMD_SEND, FUNC_PROGRAM, PARAM_GAIN2, GAIN2_MAX);
      finish_frame();
      send_item(CMD_SEND, FUNC_SIMULATE, PARAM_GAIN1, GAIN1_MAX);
      finish_frame();
      send_item(CMD_SEND, FUNC_READ, PARAM_RSV3, 8'hff);
      finish_frame();
      send_item(CMD_SEND, FUNC_READ, PARAM_RSV2, 8'h55);
      finish_frame();

      run_phase(25, 78, 200);
      run_phase(78, 25, 200);
      run_phase(0, 0, 200);

      // pulse and gap lengths cut back once each phase is under way
      set_lengths(16'd3, 16'd3, 16'd3);
      send_item(CMD_SEND, FUNC_READ, PARAM_GAIN1, 8'haa);
      tick();
      set_lengths(16'd1, 16'd0, 16'd3);
      while (!sb.in_gap) tick();
      tick();
      set_lengths(16'd1, 16'd1, 16'd0);
      finish_frame();

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
